// File: sv/ppts_pkg.sv
// ----------------------------------------------------------------------------
// ppts_pkg: shared types and constants of the perspective projection block
// Field widths, register indexes, divider geometry and the result record
// that each coordinate lane hands back to the top level.
// ----------------------------------------------------------------------------
package ppts_pkg;

	localparam int COORD_W    = 16;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int DEN_W      = COORD_W;
	localparam int SUM_W      = 34;
	localparam int SCALE_W    = 10;
	localparam int OFFSET_W   = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// The quotient is resolved to this many bits; anything larger saturates anyway.
	localparam int QUOT_BITS     = 18;
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES    = QUOT_BITS / DIV_PER_STAGE;
	localparam int COORD_LAT     = 4 + DIV_STAGES + 1;

	localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EYE_X      = 3'd0,
		CFG_EYE_Y      = 3'd1,
		CFG_EYE_Z      = 3'd2,
		CFG_PLANE_X    = 3'd3,
		CFG_SCALE      = 3'd4,
		CFG_OFFSET_COL = 3'd5,
		CFG_OFFSET_ROW = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] value;
		logic                      clip;
	} coord_res_t;

endpackage

// File: sv/ppts_in_if.sv
// ----------------------------------------------------------------------------
// ppts_in_if: vertex input channel
// Valid/ready channel carrying one vertex in signed fixed point.
// ----------------------------------------------------------------------------
interface ppts_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [ppts_pkg::COORD_W-1:0] point_x;
	logic signed [ppts_pkg::COORD_W-1:0] point_y;
	logic signed [ppts_pkg::COORD_W-1:0] point_z;

	modport source (output valid, output point_x, output point_y, output point_z,
		input ready);
	modport sink (input valid, input point_x, input point_y, input point_z,
		output ready);
endinterface

// File: sv/ppts_out_if.sv
// ----------------------------------------------------------------------------
// ppts_out_if: screen position output channel
// Valid/ready channel carrying one projected screen position and its flags.
// ----------------------------------------------------------------------------
interface ppts_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [ppts_pkg::COORD_W-1:0] screen_col;
	logic signed [ppts_pkg::COORD_W-1:0] screen_row;
	logic                                degenerate;
	logic                                clipped;

	modport source (output valid, output screen_col, output screen_row,
		output degenerate, output clipped, input ready);
	modport sink (input valid, input screen_col, input screen_row,
		input degenerate, input clipped, output ready);
endinterface

// File: sv/ppts_coord.sv
// ----------------------------------------------------------------------------
// ppts_coord: one screen coordinate lane
// Scales the projected numerator, divides it by the depth with a pipelined
// restoring divider, rounds to nearest, adds the offset and saturates.
// ----------------------------------------------------------------------------
module ppts_coord #(
	parameter int FRAC_BITS = 8
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [ppts_pkg::SUM_W-1:0]   sum,
	input  logic                                den_neg,
	input  logic [ppts_pkg::DEN_W-1:0]          den_mag,
	input  logic [ppts_pkg::SCALE_W-1:0]        scale,
	input  logic [ppts_pkg::OFFSET_W-1:0]       offset,
	output ppts_pkg::coord_res_t                res
);
	import ppts_pkg::*;

	localparam int SMAG_W = SUM_W - 1;
	localparam int MAG_W  = SMAG_W + SCALE_W;
	localparam int ACC_W  = MAG_W + 1;
	localparam int MW     = ACC_W - FRAC_BITS;
	localparam int RW     = DEN_W + QUOT_BITS;
	localparam int CW     = ((MW > RW) ? MW : RW) + 1;
	localparam int OW     = QUOT_BITS + 2;

	function automatic logic [RW:0] div_step(input logic [RW-1:0] r,
		input logic [DEN_W-1:0] d, input int unsigned sh);
		logic [RW-1:0] dsh;
		dsh = RW'(d) << sh;
		if (r >= dsh) begin
			return {1'b1, r - dsh};
		end
		return {1'b0, r};
	endfunction

	logic                 neg_s1, neg_s2, neg_s3;
	logic [SMAG_W-1:0]    smag_s1;
	logic [DEN_W-1:0]     d_s1, d_s2, d_s3;
	logic [MAG_W-1:0]     mag_s2;
	logic [MW-1:0]        m_s3;
	logic [CW-1:0]        m_ext;

	logic [RW-1:0]        rem_d [0:DIV_STAGES];
	logic [QUOT_BITS-1:0] quo_d [0:DIV_STAGES];
	logic [DEN_W-1:0]     den_d [0:DIV_STAGES];
	logic                 neg_d [0:DIV_STAGES];
	logic                 ovf_d [0:DIV_STAGES];

	logic signed [OW-1:0] sq;
	logic signed [OW-1:0] total;
	coord_res_t           res_next;

	// Stage 1: sign of the quotient and magnitude of the numerator.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= sum[SUM_W-1] ^ den_neg;
			smag_s1 <= sum[SUM_W-1] ? SMAG_W'(-sum) : SMAG_W'(sum);
			d_s1    <= den_mag;
		end
	end

	// Stage 2: scale by pixels per unit.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= neg_s1;
			mag_s2 <= MAG_W'(smag_s1) * MAG_W'(scale);
			d_s2   <= d_s1;
		end
	end

	// Stage 3: the divisor carries the fraction scale, so half of it is added
	// for rounding and the power-of-two part comes off as a shift.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3 <= neg_s2;
			m_s3   <= MW'((ACC_W'(mag_s2) + (ACC_W'(d_s2) << (FRAC_BITS - 1))) >> FRAC_BITS);
			d_s3   <= d_s2;
		end
	end

	// Stage 4: a quotient that does not fit the divider saturates later.
	assign m_ext = CW'(m_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_d[0] <= m_ext[RW-1:0];
			quo_d[0] <= '0;
			den_d[0] <= d_s3;
			neg_d[0] <= neg_s3;
			ovf_d[0] <= m_ext >= (CW'(d_s3) << QUOT_BITS);
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [RW-1:0]        rem_n;
		logic [QUOT_BITS-1:0] quo_n;

		always_comb begin
			logic [RW:0] st;
			rem_n = rem_d[k];
			quo_n = quo_d[k];
			for (int j = 0; j < DIV_PER_STAGE; j++) begin
				st    = div_step(rem_n, den_d[k],
					QUOT_BITS - 1 - k * DIV_PER_STAGE - j);
				rem_n = st[RW-1:0];
				quo_n = {quo_n[QUOT_BITS-2:0], st[RW]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_d[k+1] <= rem_n;
				quo_d[k+1] <= quo_n;
				den_d[k+1] <= den_d[k];
				neg_d[k+1] <= neg_d[k];
				ovf_d[k+1] <= ovf_d[k];
			end
		end
	end

	// Output stage: apply the sign (ties went away from zero), offset and saturate.
	always_comb begin
		sq    = neg_d[DIV_STAGES] ? -OW'(quo_d[DIV_STAGES]) : OW'(quo_d[DIV_STAGES]);
		total = sq + OW'(offset);
		if (ovf_d[DIV_STAGES]) begin
			res_next.value = neg_d[DIV_STAGES] ? COORD_MIN : COORD_MAX;
			res_next.clip  = 1'b1;
		end else if (total > OW'(COORD_MAX)) begin
			res_next.value = COORD_MAX;
			res_next.clip  = 1'b1;
		end else if (total < OW'(COORD_MIN)) begin
			res_next.value = COORD_MIN;
			res_next.clip  = 1'b1;
		end else begin
			res_next.value = COORD_W'(total);
			res_next.clip  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= res_next;
		end
	end

endmodule

// File: sv/perspective_project_to_screen_top.sv
// ----------------------------------------------------------------------------
// perspective_project_to_screen_top: pinhole projection onto a screen
// Projects each vertex from the eye point onto the plane x = plane_x and
// maps the plane coordinates to rounded, saturated screen positions.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake      payload
//  in_ch     in         valid/ready    point_x, point_y, point_z
//  out_ch    out        valid/ready    screen_col, screen_row, degenerate, clipped
//  cfg       in         cfg_we only    cfg_index, cfg_data
//
//  One vertex enters per cycle while the output is not stalled; a result passes
//  through three front stages, then per coordinate lane sign, scale, rounding
//  and divider load stages, nine divider stages (two quotient bits each) and
//  the output register. The whole pipeline advances together and holds while a
//  result waits at the output, so a stall neither drops nor repeats an item.
//  Reset clears the valid bits and loads the register defaults.
//
module perspective_project_to_screen_top #(
	parameter int FRAC_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ppts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppts_pkg::CFG_DATA_W-1:0]    cfg_data,
	ppts_in_if.sink                            in_ch,
	ppts_out_if.source                         out_ch
);
	import ppts_pkg::*;

	localparam int PIPE_LAT = 3 + COORD_LAT;

	logic signed [COORD_W-1:0] eye_x_q, eye_y_q, eye_z_q, plane_x_q;
	logic [SCALE_W-1:0]        scale_q;
	logic [OFFSET_W-1:0]       offset_col_q, offset_row_q;

	logic                      adv;
	logic [PIPE_LAT-1:0]       valid_s;
	logic [PIPE_LAT-1:0]       degen_s;

	logic signed [DIFF_W-1:0]  den_in;
	logic signed [DIFF_W-1:0]  den_s1, num_s1, dy_s1, dz_s1;
	logic signed [DIFF_W-1:0]  den_s2;
	logic signed [SUM_W-2:0]   ez_s2, ey_s2;
	logic signed [SUM_W-1:0]   nz_s2, ny_s2;
	logic signed [SUM_W-1:0]   sum_col_s3, sum_row_s3;
	logic                      den_neg_s3;
	logic [DEN_W-1:0]          den_mag_s3;

	coord_res_t                col_res, row_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_x_q      <= 16'sd2560;
			eye_y_q      <= 16'sd0;
			eye_z_q      <= 16'sd0;
			plane_x_q    <= 16'sd1280;
			scale_q      <= 10'd100;
			offset_col_q <= 12'd300;
			offset_row_q <= 12'd400;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_EYE_X:      eye_x_q      <= cfg_data;
				CFG_EYE_Y:      eye_y_q      <= cfg_data;
				CFG_EYE_Z:      eye_z_q      <= cfg_data;
				CFG_PLANE_X:    plane_x_q    <= cfg_data;
				CFG_SCALE:      scale_q      <= cfg_data[SCALE_W-1:0];
				CFG_OFFSET_COL: offset_col_q <= cfg_data[OFFSET_W-1:0];
				CFG_OFFSET_ROW: offset_row_q <= cfg_data[OFFSET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Every stage moves when the output slot is free or being taken.
	assign adv         = !valid_s[PIPE_LAT-1] || out_ch.ready;
	assign in_ch.ready = adv;

	assign den_in = DIFF_W'(in_ch.point_x) - DIFF_W'(eye_x_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[PIPE_LAT-2:0], in_ch.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			degen_s <= {degen_s[PIPE_LAT-2:0], den_in == '0};
		end
	end

	// Stage 1: differences against the eye.
	always_ff @(posedge clk) begin
		if (adv) begin
			den_s1 <= den_in;
			num_s1 <= DIFF_W'(plane_x_q) - DIFF_W'(eye_x_q);
			dy_s1  <= DIFF_W'(in_ch.point_y) - DIFF_W'(eye_y_q);
			dz_s1  <= DIFF_W'(in_ch.point_z) - DIFF_W'(eye_z_q);
		end
	end

	// Stage 2: the four products of the projected numerators.
	always_ff @(posedge clk) begin
		if (adv) begin
			den_s2 <= den_s1;
			ez_s2  <= (SUM_W - 1)'(eye_z_q) * (SUM_W - 1)'(den_s1);
			ey_s2  <= (SUM_W - 1)'(eye_y_q) * (SUM_W - 1)'(den_s1);
			nz_s2  <= SUM_W'(num_s1) * SUM_W'(dz_s1);
			ny_s2  <= SUM_W'(num_s1) * SUM_W'(dy_s1);
		end
	end

	// Stage 3: numerators and the depth split into sign and magnitude.
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_col_s3 <= SUM_W'(ez_s2) + nz_s2;
			sum_row_s3 <= SUM_W'(ey_s2) + ny_s2;
			den_neg_s3 <= den_s2[DIFF_W-1];
			den_mag_s3 <= den_s2[DIFF_W-1] ? DEN_W'(-den_s2) : DEN_W'(den_s2);
		end
	end

	ppts_coord #(
		.FRAC_BITS (FRAC_BITS)
	) u_col (
		.clk     (clk),
		.en      (adv),
		.sum     (sum_col_s3),
		.den_neg (den_neg_s3),
		.den_mag (den_mag_s3),
		.scale   (scale_q),
		.offset  (offset_col_q),
		.res     (col_res)
	);

	ppts_coord #(
		.FRAC_BITS (FRAC_BITS)
	) u_row (
		.clk     (clk),
		.en      (adv),
		.sum     (sum_row_s3),
		.den_neg (den_neg_s3),
		.den_mag (den_mag_s3),
		.scale   (scale_q),
		.offset  (offset_row_q),
		.res     (row_res)
	);

	// A point at eye depth reports zeros in place of the divider output.
	assign out_ch.valid      = valid_s[PIPE_LAT-1];
	assign out_ch.degenerate = degen_s[PIPE_LAT-1];
	assign out_ch.screen_col = degen_s[PIPE_LAT-1] ? '0 : col_res.value;
	assign out_ch.screen_row = degen_s[PIPE_LAT-1] ? '0 : row_res.value;
	assign out_ch.clipped    = !degen_s[PIPE_LAT-1] && (col_res.clip || row_res.clip);

`ifndef ASSERT_OFF
	a_stall_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s))
		else $error("pipeline valid bits moved during a stall");

	a_stall_result: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(col_res) && $stable(row_res))
		else $error("coordinate results changed during a stall");

	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.clipped |->
			(out_ch.screen_col == COORD_MAX || out_ch.screen_col == COORD_MIN ||
			 out_ch.screen_row == COORD_MAX || out_ch.screen_row == COORD_MIN))
		else $error("clipped result without a saturated coordinate");
`endif

endmodule
